>>> design/dec_pkg.sv
// shared types and constants for the double-ended queue
`default_nettype none

package dec_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int ELEM_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST_FWD   = 3'd4,
        OP_LIST_BWD   = 3'd5
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        SEL_HOLD,
        SEL_PREV,
        SEL_NEXT,
        SEL_LOAD,
        SEL_WRAP
    } t_cell_sel;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } t_state;

endpackage

`default_nettype wire

>>> design/dec_ifs.sv
// valid/ready channel interfaces for command and result words
`default_nettype none

interface dec_in_if;
    logic                         valid;
    logic                         ready;
    logic [dec_pkg::OPCODE_W-1:0] opcode;
    logic [dec_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface dec_out_if;
    logic                         valid;
    logic                         ready;
    logic [dec_pkg::ELEM_W-1:0]   element;
    logic                         element_valid;
    logic                         last;
    logic [dec_pkg::COUNT_W-1:0]  count;
    logic                         is_empty;
    logic [dec_pkg::STATUS_W-1:0] status;

    modport source (output valid, output element, output element_valid, output last,
                    output count, output is_empty, output status, input ready);
    modport sink   (input valid, input element, input element_valid, input last,
                    input count, input is_empty, input status, output ready);
endinterface

`default_nettype wire

>>> design/dec_cell.sv
// one storage cell of the queue chain
`default_nettype none

module dec_cell #(
    parameter int DATA_WIDTH = dec_pkg::DATA_WIDTH_DEF
) (
    input  wire                   i_clk,
    input  wire dec_pkg::t_cell_sel i_sel,
    input  wire  [DATA_WIDTH-1:0] i_prev,
    input  wire  [DATA_WIDTH-1:0] i_next,
    input  wire  [DATA_WIDTH-1:0] i_load,
    input  wire  [DATA_WIDTH-1:0] i_wrap,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        unique case (i_sel)
            dec_pkg::SEL_HOLD: n_data = r_data;
            dec_pkg::SEL_PREV: n_data = i_prev;
            dec_pkg::SEL_NEXT: n_data = i_next;
            dec_pkg::SEL_LOAD: n_data = i_load;
            dec_pkg::SEL_WRAP: n_data = i_wrap;
            default:           n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

>>> design/double_ended_queue.sv
// double-ended queue built as a shifting chain of cells, with its controller
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    opcode, value
//  o_out     out  valid/ready    element, element_valid, last, count, is_empty, status
//
//  push, pop, unused codes and an empty listing: one result word each
//  a listing of n elements: the command gives no word itself, then one word per cycle while the
//  output register is free; the chain rotates one step per word and is back in place
//  at the end, no new command is taken until the last word is loaded
//  reset clears the fill count and control state; cell contents are left as they are
//  a stalled output holds its word, and a command is still taken while it is being read
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = dec_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dec_pkg::DATA_WIDTH_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    dec_in_if.sink    i_in,
    dec_out_if.source o_out
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    dec_pkg::t_state r_state;
    dec_pkg::t_state n_state;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [CW-1:0]   r_left;
    logic [CW-1:0]   n_left;
    logic            r_fwd;
    logic            n_fwd;

    logic                         r_o_valid;
    logic                         n_o_valid;
    logic [dec_pkg::ELEM_W-1:0]   r_elem;
    logic [dec_pkg::ELEM_W-1:0]   n_elem;
    logic                         r_elem_v;
    logic                         n_elem_v;
    logic                         r_last;
    logic                         n_last;
    logic [dec_pkg::COUNT_W-1:0]  r_cnt;
    logic [dec_pkg::COUNT_W-1:0]  n_cnt;
    logic                         r_empty;
    logic                         n_empty;
    dec_pkg::t_status             r_status;
    dec_pkg::t_status             n_status;

    logic                  w_slot_free;
    logic                  w_in_ready;
    logic [DATA_WIDTH-1:0] w_load;
    logic [DATA_WIDTH-1:0] w_wrap;
    logic [DATA_WIDTH-1:0] w_tail;
    logic [IW-1:0]         w_tail_idx;
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_prev [DEPTH];
    logic [DATA_WIDTH-1:0] w_next [DEPTH];
    dec_pkg::t_cell_sel    w_sel  [DEPTH];

    assign w_load      = DATA_WIDTH'(i_in.value);
    assign w_tail_idx  = IW'(r_count - CW'(1));
    assign w_tail      = w_data[w_tail_idx];
    assign w_wrap      = r_fwd ? w_data[0] : w_tail;
    assign w_slot_free = !r_o_valid || o_out.ready;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev[g] = w_data[g];
        end else begin : g_mid_prev
            assign w_prev[g] = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_final
            assign w_next[g] = w_data[g];
        end else begin : g_mid_next
            assign w_next[g] = w_data[g+1];
        end

        dec_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk  (i_clk),
            .i_sel  (w_sel[g]),
            .i_prev (w_prev[g]),
            .i_next (w_next[g]),
            .i_load (w_load),
            .i_wrap (w_wrap),
            .o_data (w_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dec_pkg::S_IDLE;
            r_count   <= '0;
            r_left    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_left    <= n_left;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd    <= n_fwd;
        r_elem   <= n_elem;
        r_elem_v <= n_elem_v;
        r_last   <= n_last;
        r_cnt    <= n_cnt;
        r_empty  <= n_empty;
        r_status <= n_status;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_left     = r_left;
        n_fwd      = r_fwd;
        n_o_valid  = r_o_valid && !o_out.ready;
        n_elem     = r_elem;
        n_elem_v   = r_elem_v;
        n_last     = r_last;
        n_cnt      = r_cnt;
        n_empty    = r_empty;
        n_status   = r_status;
        w_in_ready = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            w_sel[i] = dec_pkg::SEL_HOLD;
        end

        unique case (r_state)
            dec_pkg::S_IDLE: begin
                w_in_ready = w_slot_free;
                if (i_in.valid && w_slot_free) begin
                    n_o_valid = 1'b1;
                    n_elem    = '0;
                    n_elem_v  = 1'b0;
                    n_last    = 1'b1;
                    n_status  = dec_pkg::ST_OK;
                    unique case (dec_pkg::t_opcode'(i_in.opcode))
                        dec_pkg::OP_PUSH_FRONT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = dec_pkg::ST_FULL;
                            end else begin
                                w_sel[0] = dec_pkg::SEL_LOAD;
                                for (int i = 1; i < DEPTH; i++) begin
                                    w_sel[i] = dec_pkg::SEL_PREV;
                                end
                                n_count = r_count + CW'(1);
                            end
                        end
                        dec_pkg::OP_PUSH_BACK: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = dec_pkg::ST_FULL;
                            end else begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    if (CW'(i) == r_count) begin
                                        w_sel[i] = dec_pkg::SEL_LOAD;
                                    end
                                end
                                n_count = r_count + CW'(1);
                            end
                        end
                        dec_pkg::OP_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_status = dec_pkg::ST_EMPTY;
                            end else begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    w_sel[i] = dec_pkg::SEL_NEXT;
                                end
                                n_count = r_count - CW'(1);
                            end
                        end
                        dec_pkg::OP_POP_BACK: begin
                            if (r_count == '0) begin
                                n_status = dec_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        dec_pkg::OP_LIST_FWD, dec_pkg::OP_LIST_BWD: begin
                            if (r_count != '0) begin
                                n_o_valid = 1'b0;
                                n_state   = dec_pkg::S_LIST;
                                n_left    = r_count;
                                n_fwd     = (dec_pkg::t_opcode'(i_in.opcode)
                                             == dec_pkg::OP_LIST_FWD);
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_cnt   = dec_pkg::COUNT_W'(n_count);
                    n_empty = (n_count == '0);
                end
            end
            dec_pkg::S_LIST: begin
                if (w_slot_free) begin
                    n_o_valid = 1'b1;
                    n_elem    = dec_pkg::ELEM_W'(r_fwd ? w_data[0] : w_tail);
                    n_elem_v  = 1'b1;
                    n_last    = (r_left == CW'(1));
                    n_status  = dec_pkg::ST_OK;
                    n_cnt     = dec_pkg::COUNT_W'(r_count);
                    n_empty   = (r_count == '0);
                    n_left    = r_left - CW'(1);
                    // rotate the occupied cells by one place
                    for (int i = 0; i < DEPTH; i++) begin
                        if (r_fwd) begin
                            if (CW'(i) == r_count - CW'(1)) begin
                                w_sel[i] = dec_pkg::SEL_WRAP;
                            end else if (CW'(i) < r_count) begin
                                w_sel[i] = dec_pkg::SEL_NEXT;
                            end
                        end else begin
                            if (i == 0) begin
                                w_sel[i] = dec_pkg::SEL_WRAP;
                            end else if (CW'(i) < r_count) begin
                                w_sel[i] = dec_pkg::SEL_PREV;
                            end
                        end
                    end
                    if (r_left == CW'(1)) begin
                        n_state = dec_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = dec_pkg::S_IDLE;
            end
        endcase
    end

    assign i_in.ready          = w_in_ready;
    assign o_out.valid         = r_o_valid;
    assign o_out.element       = r_elem;
    assign o_out.element_valid = r_elem_v;
    assign o_out.last          = r_last;
    assign o_out.count         = r_cnt;
    assign o_out.is_empty      = r_empty;
    assign o_out.status        = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_busy_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dec_pkg::S_LIST) |-> !i_in.ready)
        else $error("command taken during a listing");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.valid && i_in.ready) |=> $stable(r_count))
        else $error("fill count moved without a command");

    a_list_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dec_pkg::S_LIST && w_slot_free && r_left == CW'(1))
        |=> (r_state == dec_pkg::S_IDLE && r_o_valid && r_last))
        else $error("listing did not close with a final word");

endmodule

`default_nettype wire
